>>> hdl/cle_pkg.sv
// Shared types and constants for the circular list engine.
package cle_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int VALUE_BITS_DEF = 32;

   localparam logic [2:0] REQ_INS_HEAD = 3'd0;
   localparam logic [2:0] REQ_INS_TAIL = 3'd1;
   localparam logic [2:0] REQ_INS_POS  = 3'd2;
   localparam logic [2:0] REQ_DEL_HEAD = 3'd3;
   localparam logic [2:0] REQ_DEL_TAIL = 3'd4;
   localparam logic [2:0] REQ_DEL_POS  = 3'd5;
   localparam logic [2:0] REQ_DEL_VAL  = 3'd6;
   localparam logic [2:0] REQ_NONE     = 3'd7;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_BADPOS   = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   // datapath commands
   typedef enum logic [3:0] {
      CMD_NONE    = 4'd0,
      CMD_LOAD    = 4'd1,  // latch request, cursor <= tail, counter <= 0, read free top
      CMD_RD_NEXT = 4'd2,  // read next of cursor
      CMD_STEP    = 4'd3,  // cursor <= read next, counter++
      CMD_RD_VAL  = 4'd4,  // read value of read-next slot
      CMD_INS_A   = 4'd5,  // alloc slot, write value, next of new <= next of prev
      CMD_INS_B   = 4'd6,  // next of prev <= new slot, update tail/count
      CMD_INS_ONE = 4'd7,  // first node
      CMD_DEL_A   = 4'd8,  // read victim value and successor (victim = read next)
      CMD_DEL_B   = 4'd9,  // relink, free, update tail/count
      CMD_RESP    = 4'd10  // load response register
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       upd_tail;   // INS_B: make new node tail
      logic [2:0] status;
   } ctl_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [6:0] position;
      logic       empty;
      logic       full;
      logic       walk_done;    // walk counter reached its target
      logic       val_match;
      logic       prev_is_tail;
      logic       ins_pos_bad;  // position outside 1 to count+1
      logic       del_pos_bad;  // position outside 1 to count
      logic       walk_last;    // value search at its last node
   } sts_type;

endpackage

>>> hdl/cle_datapath.sv
// Node memories, free stack, pointers and response register.
module cle_datapath #(
   parameter int CAPACITY   = cle_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = cle_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0]            in_type,
   input  logic [6:0]            in_pos,
   input  logic [31:0]           in_value,
   input  cle_pkg::ctl_type      ctl,
   output cle_pkg::sts_type      sts,
   output logic                  ready,
   output logic [2:0]            out_status,
   output logic [31:0]           out_removed,
   output logic [6:0]            out_count
);
   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > 7) ? CW : 7) + 1;

   logic [VALUE_BITS-1:0] val_mem [CAPACITY];
   logic [SW-1:0]         nxt_mem [CAPACITY];
   logic [SW-1:0]         free_mem [CAPACITY];

   logic [2:0]  type_ff;
   logic [6:0]  pos_ff;
   logic [VALUE_BITS-1:0] key_ff;
   logic [SW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ftop_ff, ftop_in;
   logic [CW-1:0] init_ff;
   logic [SW-1:0] cur_ff, succ_ff, nxt_rd_ff, new_ff;
   logic [SW-1:0] free_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [CW-1:0] walk_ff;
   logic [CW-1:0] target;
   logic [VALUE_BITS-1:0] key_in;
   logic [2:0]  rs_status_ff;
   logic [31:0] rs_removed_ff;
   logic [6:0]  rs_count_ff;
   logic [VALUE_BITS-1:0] rem_ff;

   assign key_in = VALUE_BITS'(in_value);
   assign ready  = (init_ff == CW'(CAPACITY));

   always_comb begin
      case (type_ff)
         cle_pkg::REQ_DEL_TAIL: target = count_ff - CW'(1);
         default:               target = CW'(pos_ff) - CW'(1);
      endcase
   end

   assign sts.req_type     = type_ff;
   assign sts.position     = pos_ff;
   assign sts.empty        = (count_ff == '0);
   assign sts.full         = (ftop_ff == '0);
   assign sts.walk_done    = (walk_ff >= target);
   assign sts.val_match    = (val_rd_ff == key_ff);
   assign sts.prev_is_tail = (cur_ff == tail_ff);
   assign sts.ins_pos_bad  = (pos_ff == '0) || (PW'(pos_ff) > PW'(count_ff) + PW'(1));
   assign sts.del_pos_bad  = (pos_ff == '0) || (PW'(pos_ff) > PW'(count_ff));
   assign sts.walk_last    = (walk_ff + CW'(1) >= count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff  <= '0;
         count_ff <= '0;
         ftop_ff  <= CW'(CAPACITY);
         init_ff  <= '0;
      end else begin
         tail_ff  <= tail_in;
         count_ff <= count_in;
         ftop_ff  <= ftop_in;
         if (init_ff < CW'(CAPACITY))
            init_ff <= init_ff + CW'(1);
      end
   end

   // fill the free stack with all slots in order after reset
   always_ff @(posedge clock) begin
      if (!reset && init_ff < CW'(CAPACITY)) begin
         free_mem[SW'(init_ff)] <= SW'(init_ff);
      end else if (ctl.cmd == cle_pkg::CMD_DEL_B) begin
         free_mem[SW'(ftop_ff)] <= nxt_rd_ff;
      end
      if (ctl.cmd == cle_pkg::CMD_LOAD)
         free_rd_ff <= free_mem[SW'(ftop_ff - CW'(1))];
   end

   always_comb begin
      tail_in  = tail_ff;
      count_in = count_ff;
      ftop_in  = ftop_ff;
      case (ctl.cmd)
         cle_pkg::CMD_INS_ONE: begin
            tail_in  = free_rd_ff;
            count_in = CW'(1);
            ftop_in  = ftop_ff - CW'(1);
         end
         cle_pkg::CMD_INS_A: ftop_in = ftop_ff - CW'(1);
         cle_pkg::CMD_INS_B: begin
            count_in = count_ff + CW'(1);
            if (ctl.upd_tail) tail_in = new_ff;
         end
         cle_pkg::CMD_DEL_B: begin
            count_in = count_ff - CW'(1);
            ftop_in  = ftop_ff + CW'(1);
            if (count_ff == CW'(1)) tail_in = '0;
            else if (nxt_rd_ff == tail_ff) tail_in = cur_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      case (ctl.cmd)
         cle_pkg::CMD_LOAD: begin
            type_ff <= in_type;
            pos_ff  <= in_pos;
            key_ff  <= key_in;
            cur_ff  <= tail_ff;
            walk_ff <= '0;
         end
         cle_pkg::CMD_RD_NEXT: nxt_rd_ff <= nxt_mem[cur_ff];
         cle_pkg::CMD_STEP: begin
            cur_ff  <= nxt_rd_ff;
            walk_ff <= walk_ff + CW'(1);
         end
         cle_pkg::CMD_RD_VAL: val_rd_ff <= val_mem[nxt_rd_ff];
         cle_pkg::CMD_INS_ONE: begin
            val_mem[free_rd_ff] <= key_ff;
            nxt_mem[free_rd_ff] <= free_rd_ff;
         end
         cle_pkg::CMD_INS_A: begin
            new_ff <= free_rd_ff;
            val_mem[free_rd_ff] <= key_ff;
            nxt_mem[free_rd_ff] <= nxt_rd_ff;
         end
         cle_pkg::CMD_INS_B: nxt_mem[cur_ff] <= new_ff;
         cle_pkg::CMD_DEL_A: begin
            rem_ff  <= val_mem[nxt_rd_ff];
            succ_ff <= nxt_mem[nxt_rd_ff];
         end
         cle_pkg::CMD_DEL_B: if (count_ff != CW'(1)) nxt_mem[cur_ff] <= succ_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.cmd == cle_pkg::CMD_RESP) begin
         rs_status_ff  <= ctl.status;
         rs_removed_ff <= (ctl.status == cle_pkg::ST_OK && type_ff >= cle_pkg::REQ_DEL_HEAD
                           && type_ff != cle_pkg::REQ_NONE) ? 32'(rem_ff) : 32'd0;
         rs_count_ff   <= 7'(count_ff);
      end
   end

   assign out_status  = rs_status_ff;
   assign out_removed = rs_removed_ff;
   assign out_count   = rs_count_ff;
endmodule

>>> hdl/cle_control.sv
// Command sequencer for the circular list engine.
module cle_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic             dp_ready,
   input  cle_pkg::sts_type sts,
   output cle_pkg::ctl_type ctl
);
   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_DEC   = 11'b00000000010,
      S_RDN   = 11'b00000000100,
      S_WALK  = 11'b00000001000,
      S_RDV   = 11'b00000010000,
      S_CMP   = 11'b00000100000,
      S_INSA  = 11'b00001000000,
      S_INSB  = 11'b00010000000,
      S_DELA  = 11'b00100000000,
      S_DELB  = 11'b01000000000,
      S_RESP  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] status_ff, status_in;
   logic       vld_ff, vld_in;
   logic       tl_ff, tl_in;

   assign req_tready = (state_ff == S_IDLE) && dp_ready;
   assign rsp_tvalid = vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
         status_ff <= cle_pkg::ST_OK;
         tl_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         vld_ff    <= vld_in;
         status_ff <= status_in;
         tl_ff     <= tl_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      tl_in     = tl_ff;
      vld_in    = vld_ff && !rsp_tready;
      ctl.cmd   = cle_pkg::CMD_NONE;
      ctl.upd_tail = tl_ff;
      ctl.status = status_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            ctl.cmd  = cle_pkg::CMD_LOAD;
            status_in = cle_pkg::ST_OK;
            tl_in    = 1'b0;
            state_in = S_DEC;
         end
         S_DEC: begin
            state_in = S_RESP;
            case (sts.req_type)
               cle_pkg::REQ_INS_HEAD, cle_pkg::REQ_INS_TAIL, cle_pkg::REQ_INS_POS: begin
                  if (sts.req_type == cle_pkg::REQ_INS_POS && sts.ins_pos_bad)
                     status_in = cle_pkg::ST_BADPOS;
                  else if (sts.full) status_in = cle_pkg::ST_FULL;
                  else if (sts.empty) ctl.cmd = cle_pkg::CMD_INS_ONE;
                  else begin
                     tl_in = (sts.req_type == cle_pkg::REQ_INS_TAIL);
                     state_in = (sts.req_type == cle_pkg::REQ_INS_POS) ? S_WALK : S_RDN;
                  end
               end
               cle_pkg::REQ_DEL_HEAD, cle_pkg::REQ_DEL_TAIL, cle_pkg::REQ_DEL_POS,
               cle_pkg::REQ_DEL_VAL: begin
                  if (sts.empty) status_in = cle_pkg::ST_EMPTY;
                  else if (sts.req_type == cle_pkg::REQ_DEL_POS && sts.del_pos_bad)
                     status_in = cle_pkg::ST_BADPOS;
                  else if (sts.req_type == cle_pkg::REQ_DEL_HEAD) state_in = S_RDN;
                  else if (sts.req_type == cle_pkg::REQ_DEL_VAL) state_in = S_RDN;
                  else state_in = S_WALK;
               end
               default: ;
            endcase
         end
         // walk: cursor starts at tail; each step moves one node forward
         S_WALK: begin
            if (sts.walk_done) state_in = S_RDN;
            else begin
               ctl.cmd  = cle_pkg::CMD_RD_NEXT;
               state_in = S_CMP;
            end
         end
         S_RDN: begin
            ctl.cmd = cle_pkg::CMD_RD_NEXT;
            if (sts.req_type == cle_pkg::REQ_DEL_VAL) state_in = S_RDV;
            else if (sts.req_type <= cle_pkg::REQ_INS_POS) state_in = S_INSA;
            else state_in = S_DELA;
         end
         S_RDV: begin
            ctl.cmd  = cle_pkg::CMD_RD_VAL;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sts.req_type == cle_pkg::REQ_DEL_VAL) begin
               if (sts.val_match) state_in = S_DELA;
               else if (sts.walk_last) begin
                  status_in = cle_pkg::ST_NOTFOUND;
                  state_in  = S_RESP;
               end else begin
                  ctl.cmd  = cle_pkg::CMD_STEP;
                  state_in = S_RDN;
               end
            end else begin
               ctl.cmd  = cle_pkg::CMD_STEP;
               state_in = S_WALK;
            end
         end
         S_INSA: begin
            ctl.cmd  = cle_pkg::CMD_INS_A;
            tl_in    = tl_ff || (sts.req_type == cle_pkg::REQ_INS_POS && sts.prev_is_tail
                                 && sts.position != 7'd1);
            state_in = S_INSB;
         end
         S_INSB: begin
            ctl.cmd  = cle_pkg::CMD_INS_B;
            state_in = S_RESP;
         end
         S_DELA: begin
            ctl.cmd  = cle_pkg::CMD_DEL_A;
            state_in = S_DELB;
         end
         S_DELB: begin
            ctl.cmd  = cle_pkg::CMD_DEL_B;
            state_in = S_RESP;
         end
         S_RESP: if (!vld_ff || rsp_tready) begin
            ctl.cmd  = cle_pkg::CMD_RESP;
            vld_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> hdl/circular_list_engine_unit.sv
// Top level of the circular list engine.
// Requests arrive on req_ (tdata: req_type[2:0], position[9:3], value[41:10]).
// Each accepted request yields exactly one response on rsp_
// (tdata: status[2:0], removed_value[34:3], entry_count[41:35]).
// One request is processed at a time. An error, a no-operation or the first
// insert into an empty list goes from decode straight to the response; head
// and tail inserts and head deletes read the tail's next pointer and then
// insert or delete in two steps. Position inserts, position deletes and tail
// deletes first walk the linked nodes from the tail, one node per step.
// A delete by value reads and compares each node's value in turn. The response
// is valid from the same cycle in which the next request can be accepted.
// After reset the list is empty; the free-slot stack is filled by a sweep of
// all CAPACITY slots during which req_tready stays low.
// The response is held in an output register until rsp_tready. One more
// request is accepted and processed meanwhile; its response waits, and
// req_tready stays low, until the held response is taken.
module circular_list_engine_unit #(
   parameter int CAPACITY   = cle_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = cle_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // req_type, position, value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // status, removed_value, entry_count
);
   cle_pkg::ctl_type ctl;
   cle_pkg::sts_type sts;
   logic        dp_rdy;
   logic [2:0]  st;
   logic [31:0] rm;
   logic [6:0]  cnt;

   cle_datapath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock, .reset,
      .in_type(req_tdata[2:0]), .in_pos(req_tdata[9:3]), .in_value(req_tdata[41:10]),
      .ctl, .sts, .ready(dp_rdy), .out_status(st), .out_removed(rm), .out_count(cnt)
   );

   cle_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .dp_ready(dp_rdy), .sts, .ctl
   );

   assign rsp_tdata = {6'd0, cnt, rm, st};
endmodule

>>> sim/circular_list_engine_unit_tb.sv
// Self-checking testbench for the circular list engine: random list commands against a queue model.
module circular_list_engine_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = cle_pkg::CAPACITY_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] value;
      logic [6:0]  position;
      logic [2:0]  req_type;
   } list_cmd_type;

   typedef struct packed {
      logic [6:0]  entry_count;
      logic [31:0] removed_value;
      logic [2:0]  status;
   } list_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // req_type, position, value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;    // status, removed_value, entry_count

   list_cmd_type pending_cmds[$];
   list_rsp_type expected_rsps[$];
   logic [31:0] model_list[$];
   int          mismatch_count = 0;
   int          rsp_count = 0;
   int          hold_cycles = 0;
   int          calm_cycles = 0;
   int          idle_cycles;
   bit          stim_done;
   int          op_hist[8];

   circular_list_engine_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic list_rsp_type apply_list_cmd(list_cmd_type c);
      list_rsp_type r;
      int n;
      int p;
      bit found;
      r = '0;
      n = model_list.size();
      p = int'(c.position);
      case (c.req_type)
         cle_pkg::REQ_INS_HEAD, cle_pkg::REQ_INS_TAIL, cle_pkg::REQ_INS_POS: begin
            if (c.req_type == cle_pkg::REQ_INS_POS && (p < 1 || p > n + 1))
               r.status = cle_pkg::ST_BADPOS;
            else if (n == CAP)
               r.status = cle_pkg::ST_FULL;
            else if (c.req_type == cle_pkg::REQ_INS_HEAD)
               model_list.push_front(c.value);
            else if (c.req_type == cle_pkg::REQ_INS_TAIL)
               model_list.push_back(c.value);
            else
               model_list.insert(p - 1, c.value);
         end
         cle_pkg::REQ_DEL_HEAD, cle_pkg::REQ_DEL_TAIL, cle_pkg::REQ_DEL_POS,
         cle_pkg::REQ_DEL_VAL: begin
            if (n == 0)
               r.status = cle_pkg::ST_EMPTY;
            else if (c.req_type == cle_pkg::REQ_DEL_HEAD)
               r.removed_value = model_list.pop_front();
            else if (c.req_type == cle_pkg::REQ_DEL_TAIL)
               r.removed_value = model_list.pop_back();
            else if (c.req_type == cle_pkg::REQ_DEL_POS) begin
               if (p < 1 || p > n)
                  r.status = cle_pkg::ST_BADPOS;
               else begin
                  r.removed_value = model_list[p - 1];
                  model_list.delete(p - 1);
               end
            end else begin
               found = 1'b0;
               for (int i = 0; i < n && !found; i++) begin
                  if (model_list[i] == c.value) begin
                     found = 1'b1;
                     r.removed_value = model_list[i];
                     model_list.delete(i);
                  end
               end
               if (!found)
                  r.status = cle_pkg::ST_NOTFOUND;
            end
         end
         default: ;
      endcase
      r.entry_count = 7'(model_list.size());
      return r;
   endfunction

   task automatic add_cmd(logic [2:0] t, int p, int v);
      list_cmd_type c;
      c.req_type = t;
      c.position = 7'(p);
      c.value = 32'(v);
      pending_cmds.push_back(c);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return $urandom;
         default: return 32'($urandom_range(0, 15));
      endcase
   endfunction

   initial begin
      int depth;
      int burst;
      logic [2:0] t;
      reset = 1'b1;
      stim_done = 1'b0;
      // directed: every error path, extremes, unused type
      add_cmd(cle_pkg::REQ_DEL_HEAD, 0, 0);
      add_cmd(cle_pkg::REQ_DEL_TAIL, 0, 0);
      add_cmd(cle_pkg::REQ_DEL_POS, 1, 0);
      add_cmd(cle_pkg::REQ_DEL_VAL, 0, 5);
      add_cmd(cle_pkg::REQ_INS_POS, 2, 1);
      add_cmd(cle_pkg::REQ_INS_POS, 0, 1);
      add_cmd(cle_pkg::REQ_INS_POS, 1, 32'h8000_0000);
      add_cmd(cle_pkg::REQ_INS_HEAD, 7'h7F, 32'h7FFF_FFFF);
      add_cmd(cle_pkg::REQ_INS_TAIL, 0, 32'hFFFF_FFFF);
      add_cmd(cle_pkg::REQ_INS_POS, 4, 32'h0000_0000);
      add_cmd(cle_pkg::REQ_INS_POS, 3, 32'h5555_5555);
      add_cmd(cle_pkg::REQ_INS_POS, 7'h7F, 32'hAAAA_AAAA);
      add_cmd(cle_pkg::REQ_DEL_POS, 0, 0);
      add_cmd(cle_pkg::REQ_DEL_POS, 6, 0);
      add_cmd(cle_pkg::REQ_DEL_POS, 3, 0);
      add_cmd(cle_pkg::REQ_DEL_VAL, 0, 32'h1234_5678);
      add_cmd(cle_pkg::REQ_DEL_VAL, 0, 32'hFFFF_FFFF);
      add_cmd(cle_pkg::REQ_NONE, 7'h55, 32'hDEAD_BEEF);
      add_cmd(cle_pkg::REQ_DEL_TAIL, 0, 0);
      add_cmd(cle_pkg::REQ_DEL_HEAD, 0, 0);
      add_cmd(cle_pkg::REQ_DEL_HEAD, 0, 0);
      for (int i = 0; i < CAP + 2; i++)
         add_cmd(cle_pkg::REQ_INS_TAIL, 0, $urandom);
      add_cmd(cle_pkg::REQ_INS_HEAD, 0, 1);
      add_cmd(cle_pkg::REQ_INS_POS, CAP + 1, 1);
      add_cmd(cle_pkg::REQ_DEL_POS, CAP, 0);
      add_cmd(cle_pkg::REQ_DEL_POS, CAP + 1, 0);
      // random: track list depth to hold the list near sizes of interest
      depth = 0;
      for (int i = 0; i < 560; i++) begin
         burst = $urandom_range(0, 99);
         if (burst < 45 && depth < CAP)
            t = 3'($urandom_range(0, 2));
         else if (burst < 55)
            t = 3'($urandom_range(0, 7));
         else
            t = 3'($urandom_range(3, 6));
         add_cmd(t, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(0, depth + 2),
                 pick_value());
         if (t <= cle_pkg::REQ_INS_POS) depth++;
         else if (t != cle_pkg::REQ_NONE && depth > 0) depth--;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0 && !req_tvalid);
      wait (expected_rsps.size() == 0);
      repeat (3 * CAP + 20) @(posedge clock);
      stim_done = 1'b1;
      $display("Ran %0d commands: ins %0d/%0d/%0d del %0d/%0d/%0d/%0d nop %0d, list up to full.",
               rsp_count, op_hist[0], op_hist[1], op_hist[2], op_hist[3], op_hist[4],
               op_hist[5], op_hist[6], op_hist[7]);
      if (mismatch_count == 0 && expected_rsps.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         calm_cycles <= calm_cycles + 1;
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_list_cmd(list_cmd_type'(req_tdata[41:0])));
            op_hist[req_tdata[2:0]]++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() > 0 &&
                ((calm_cycles > 1500 && calm_cycles < 4000) ||
                 $urandom_range(0, 99) >= 21)) begin
               req_tdata <= {6'b0, pending_cmds.pop_front()};
               req_tvalid <= 1'b1;
            end else
               req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[41:0];
            rsp_count <= rsp_count + 1;
            if (expected_rsps.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected response %h, expected none", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: status %0d/%0d removed %h/%h count %0d/%0d",
                              want.status, got.status, want.removed_value,
                              got.removed_value, want.entry_count, got.entry_count);
               end
            end
         end
         if (calm_cycles == 1000)
            hold_cycles <= 400;
         else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
         rsp_tready <= (hold_cycles <= 1) &&
                       ((calm_cycles > 1500 && calm_cycles < 4000) ||
                        $urandom_range(0, 99) >= 21);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (!stim_done) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress");
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end
endmodule
